// ===== rtl/rpn_pkg.sv =====
`default_nettype none

package rpn_pkg;

    // Widths fixed by the character and result formats.
    localparam int CHAR_W     = 8;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int DIV_CNT_W  = $clog2(VALUE_W);

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_RESULT    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = STATUS_W'(3);
    localparam logic [STATUS_W-1:0] ST_QUIT      = STATUS_W'(4);

    // ASCII codes recognised by the decoder.
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_B,
        S_RD_A,
        S_CAPT,
        S_DIV,
        S_FIX,
        S_WRITE,
        S_POP,
        S_POP_DATA,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/rpn_char_if.sv =====
`default_nettype none

interface rpn_char_if import rpn_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

`default_nettype wire

// ===== rtl/rpn_result_if.sv =====
`default_nettype none

interface rpn_result_if import rpn_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value;
    logic        [STATUS_W-1:0] status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/rpn_ram.sv =====
`default_nettype none

module rpn_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/rpn_stack_calculator.sv =====
// Reverse-Polish calculator taking one ASCII character per transfer.
// The input channel (i_char) carries one character per transfer; the output
// channel (o_result) carries a signed 32-bit value and a 3-bit status.
// A digit pushes its value, an operator pops two operands and pushes the
// result, '=' pops and sends the top of the stack with status 0, and a
// lowercase letter sends a quit status. Other characters are dropped.
// Overflow, underflow, division by zero and quit all halt the block: from
// then on every character is accepted and dropped until reset.
// A character is taken only in the idle state, so none is accepted while
// an operation or a result is under way. An operator reads its operands in
// S_RD_B and S_RD_A, computes in S_CAPT and writes back in S_WRITE; a
// division by a nonzero divisor runs S_DIV and S_FIX before S_WRITE, and
// one by zero goes to S_EMIT. '=' passes S_POP and S_POP_DATA to S_EMIT.
// The restoring divider retires one quotient bit per cycle through the
// shared adder. The stack sits in a single RAM with a registered read port.
// A result waits in an output register; if the receiver stalls, the block
// holds in its emit state and accepts no character until the register is
// free. Reset (i_rst_n low, synchronous) empties the stack, clears the halt
// flag and drops any waiting result; stack contents are not cleared.

`default_nettype none

module rpn_stack_calculator import rpn_pkg::*; #(
    parameter int STACK_DEPTH = 128
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    rpn_char_if.sink      i_char,
    rpn_result_if.source  o_result
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

    // Control registers.
    t_state              r_state, n_state;
    logic [SPW-1:0]      r_sp, n_sp;
    logic                r_halted, n_halted;
    logic                r_out_valid, n_out_valid;

    // Datapath registers.
    t_op                 r_op, n_op;
    logic [VALUE_W-1:0]  r_b, n_b;
    logic [VALUE_W-1:0]  r_rem, n_rem;
    logic [VALUE_W-1:0]  r_quo, n_quo;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                r_neg, n_neg;
    logic [VALUE_W-1:0]  r_res, n_res;
    logic [STATUS_W-1:0] r_sts, n_sts;
    logic [VALUE_W-1:0]  r_out_value, n_out_value;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    // Stack memory port.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;

    // Decode of the incoming character.
    logic                w_accept;
    logic                w_is_digit;
    logic                w_is_op;
    logic                w_is_eq;
    logic                w_is_letter;
    t_op                 w_op;
    logic                w_full;
    logic                w_out_free;

    // Shared adder, used for add, subtract, divider steps and sign fix-up.
    logic [VALUE_W-1:0]  w_x, w_y;
    logic                w_inv;
    logic [VALUE_W:0]    w_sum;
    logic [VALUE_W-1:0]  w_shift;
    logic [VALUE_W-1:0]  w_prod;
    logic [VALUE_W-1:0]  w_mag_a, w_mag_b;

    assign w_accept   = i_char.valid && i_char.ready;
    assign w_full     = (r_sp == SP_FULL);
    assign w_out_free = !r_out_valid || o_result.ready;

    assign i_char.ready    = (r_state == S_IDLE);
    assign o_result.valid  = r_out_valid;
    assign o_result.value  = r_out_value;
    assign o_result.status = r_out_status;

    always_comb begin
        w_is_digit  = i_char.character inside {[CH_ZERO:CH_NINE]};
        w_is_letter = i_char.character inside {[CH_LOW_A:CH_LOW_Z]};
        w_is_eq     = (i_char.character == CH_EQUAL);
        w_is_op     = 1'b1;
        w_op        = OP_ADD;
        case (i_char.character)
            CH_PLUS:  w_op = OP_ADD;
            CH_MINUS: w_op = OP_SUB;
            CH_STAR:  w_op = OP_MUL;
            CH_SLASH: w_op = OP_DIV;
            default:  w_is_op = 1'b0;
        endcase
    end

    // Operand steering for the shared adder. With w_inv set it subtracts,
    // and the carry out then means "no borrow".
    always_comb begin
        w_x   = ram_rdata;
        w_y   = r_b;
        w_inv = 1'b0;
        case (r_state)
            S_CAPT: begin
                w_inv = (r_op == OP_SUB);
            end
            S_DIV: begin
                w_x   = w_shift;
                w_inv = 1'b1;
            end
            S_FIX: begin
                w_x   = '0;
                w_y   = r_quo;
                w_inv = r_neg;
            end
            default: begin
                w_inv = 1'b0;
            end
        endcase
    end

    assign w_sum   = {1'b0, w_x} + {1'b0, w_y ^ {VALUE_W{w_inv}}} + (VALUE_W + 1)'(w_inv);
    assign w_shift = {r_rem[VALUE_W-2:0], r_quo[VALUE_W-1]};
    assign w_prod  = ram_rdata * r_b;
    assign w_mag_a = ram_rdata[VALUE_W-1] ? (VALUE_W'(0) - ram_rdata) : ram_rdata;
    assign w_mag_b = r_b[VALUE_W-1] ? (VALUE_W'(0) - r_b) : r_b;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && !r_halted) begin
                    if (w_is_digit) begin
                        n_state = w_full ? S_EMIT : S_IDLE;
                    end else if (w_is_op) begin
                        n_state = (r_sp < SPW'(2)) ? S_EMIT : S_RD_B;
                    end else if (w_is_eq) begin
                        n_state = (r_sp == '0) ? S_EMIT : S_POP;
                    end else if (w_is_letter) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_RD_B:     n_state = S_RD_A;
            S_RD_A:     n_state = S_CAPT;
            S_CAPT: begin
                if (r_op == OP_DIV) begin
                    n_state = (r_b == '0) ? S_EMIT : S_DIV;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_DIV:      n_state = (r_cnt == '1) ? S_FIX : S_DIV;
            S_FIX:      n_state = S_WRITE;
            S_WRITE:    n_state = S_IDLE;
            S_POP:      n_state = S_POP_DATA;
            S_POP_DATA: n_state = S_EMIT;
            S_EMIT:     n_state = w_out_free ? S_IDLE : S_EMIT;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_sp         = r_sp;
        n_halted     = r_halted;
        n_out_valid  = r_out_valid;
        n_op         = r_op;
        n_b          = r_b;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_cnt        = r_cnt;
        n_neg        = r_neg;
        n_res        = r_res;
        n_sts        = r_sts;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = r_sp[AW-1:0];
        ram_wdata    = {{(VALUE_W - 4){1'b0}}, i_char.character[3:0]};
        ram_raddr    = AW'(r_sp - SPW'(1));

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                n_op  = w_op;
                n_res = '0;
                if (w_accept && !r_halted) begin
                    if (w_is_digit) begin
                        if (w_full) begin
                            n_sts = ST_OVERFLOW;
                        end else begin
                            ram_we = 1'b1;
                            n_sp   = r_sp + SPW'(1);
                        end
                    end else if (w_is_op || w_is_eq) begin
                        n_sts = ST_UNDERFLOW;
                    end else if (w_is_letter) begin
                        n_sts = ST_QUIT;
                    end
                end
            end
            S_RD_A: begin
                n_b       = ram_rdata;
                ram_raddr = AW'(r_sp - SPW'(2));
            end
            S_CAPT: begin
                case (r_op)
                    OP_ADD, OP_SUB: n_res = w_sum[VALUE_W-1:0];
                    OP_MUL:         n_res = w_prod;
                    default: begin
                        n_sts = ST_DIVZERO;
                        n_res = '0;
                        n_rem = '0;
                        n_quo = w_mag_a;
                        n_b   = w_mag_b;
                        n_neg = ram_rdata[VALUE_W-1] ^ r_b[VALUE_W-1];
                        n_cnt = '0;
                    end
                endcase
            end
            S_DIV: begin
                // One restoring step: keep the difference when no borrow.
                n_rem = w_sum[VALUE_W] ? w_sum[VALUE_W-1:0] : w_shift;
                n_quo = {r_quo[VALUE_W-2:0], w_sum[VALUE_W]};
                n_cnt = r_cnt + DIV_CNT_W'(1);
            end
            S_FIX: begin
                n_res = w_sum[VALUE_W-1:0];
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_sp - SPW'(2));
                ram_wdata = r_res;
                n_sp      = r_sp - SPW'(1);
            end
            S_POP_DATA: begin
                n_res = ram_rdata;
                n_sts = ST_RESULT;
                n_sp  = r_sp - SPW'(1);
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res;
                    n_out_status = r_sts;
                    if (r_sts != ST_RESULT) begin
                        n_halted = 1'b1;
                    end
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_b          <= n_b;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_cnt        <= n_cnt;
        r_neg        <= n_neg;
        r_res        <= n_res;
        r_sts        <= n_sts;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    rpn_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STACK_DEPTH),
        .ADDR_W(AW)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // The operand count never passes the stack depth.
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_FULL)
        else $error("stack pointer beyond stack depth");

    // A halted block drops characters without touching the stack.
    a_halt_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halted && w_accept) |=> ($stable(r_sp) && r_halted))
        else $error("stack changed while halted");

    // Any non-result status on the output goes with the halt flag.
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.status != ST_RESULT)) |-> r_halted)
        else $error("error or quit sent without halting");

    // The divider runs its full count before the sign fix-up.
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt != '1) |=> (r_state == S_DIV))
        else $error("divider left early");

endmodule

`default_nettype wire
